// ----- rtl/core/bul_pkg.sv -----
`timescale 1ns / 1ps

package bul_pkg;

	localparam int WordW = 32;
	localparam int KindW = 3;

	typedef logic signed [WordW-1:0] word_t;
	typedef logic [KindW-1:0]        kind_t;

	// request codes
	localparam kind_t KIND_APPEND       = 3'd0;
	localparam kind_t KIND_FRONT        = 3'd1;
	localparam kind_t KIND_REMOVE_FIRST = 3'd2;
	localparam kind_t KIND_REMOVE_ALL   = 3'd3;
	localparam kind_t KIND_REMOVE_MIN   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_SCAN_MIN,
		ST_SCAN_DROP,
		ST_DONE
	} state_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic  shl;      // take the right neighbor
		logic  shr;      // take the left neighbor
		word_t wr_data;  // data for the addressed cell
	} cell_ctl_t;

endpackage

// ----- rtl/core/bul_cell.sv -----
`timescale 1ns / 1ps

module bul_cell (
	input  logic              clk,
	input  bul_pkg::cell_ctl_t ctl,
	input  logic              wr_en,
	input  bul_pkg::word_t    left_d,
	input  bul_pkg::word_t    right_d,
	output bul_pkg::word_t    q
);

	bul_pkg::word_t entry_q;

	// a direct write wins over a shift
	always_ff @(posedge clk) begin
		priority if (wr_en) begin
			entry_q <= ctl.wr_data;
		end else if (ctl.shl) begin
			entry_q <= right_d;
		end else if (ctl.shr) begin
			entry_q <= left_d;
		end else begin
			entry_q <= entry_q;
		end
	end

	assign q = entry_q;

endmodule

// ----- rtl/core/bounded_unsorted_list.sv -----
`timescale 1ns / 1ps

// Channel  | handshake            | payload
// ---------+----------------------+---------------------------------
// request  | req_valid, req_ready | kind [2:0], value [31:0] signed
// response | rsp_valid, rsp_ready | ok, count, removed_value [31:0]
//
// Append and front insert pass through the apply and done states before the
// response is loaded; remove first and remove all make one rotation step of the
// cell row per stored entry, remove minimum one rotation to find and one to drop.
// Removals on an empty list and unused kinds go straight to the done state.
// Reset clears the state, the fill count and the response valid flag only; cell contents are don't-care until written.
// A stalled response holds in its own register; the next request is still taken.

module bounded_unsorted_list #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [bul_pkg::KindW-1:0]        kind,
	input  logic signed [bul_pkg::WordW-1:0] value,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             ok,
	output logic [$clog2(DEPTH+1)-1:0]       count,
	output logic signed [bul_pkg::WordW-1:0] removed_value
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	bul_pkg::state_t state_q, state_d;

	// control and working registers
	logic [CW-1:0]      fill_q;
	logic [CW-1:0]      steps_q;
	bul_pkg::kind_t     kind_q;
	bul_pkg::word_t     key_q;
	bul_pkg::word_t     min_q;
	logic               dropped_q;
	logic               res_ok_q;
	bul_pkg::word_t     res_rm_q;

	// response register
	logic               rsp_valid_q;
	logic               ok_q;
	logic [CW-1:0]      count_q;
	bul_pkg::word_t     removed_q;

	// cell row
	bul_pkg::word_t     cell_q [DEPTH];
	bul_pkg::cell_ctl_t ctl;
	logic               wr_any;
	logic [IW-1:0]      wr_idx;

	bul_pkg::word_t     head;
	bul_pkg::word_t     min_next;
	logic               head_lt;
	logic               drop_now;
	logic               room;
	logic               empty;
	logic               last_step;
	logic               rsp_free;
	logic               rsp_load;

	assign head      = cell_q[0];
	assign head_lt   = head < min_q;
	assign min_next  = head_lt ? head : min_q;
	// remove all drops every match, the other removals only the first
	assign drop_now  = (head == key_q) &&
		((kind_q == bul_pkg::KIND_REMOVE_ALL) || !dropped_q);
	assign room      = fill_q < CW'(DEPTH);
	assign empty     = fill_q == '0;
	assign last_step = steps_q == CW'(1);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = (state_q == bul_pkg::ST_DONE) && rsp_free;

	// Each cell takes its right neighbor on a rotation step; the cell at the
	// tail of the live region takes the outgoing head unless it is dropped.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		bul_pkg::word_t left_d;
		bul_pkg::word_t right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_q[i+1];
		end

		bul_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_en   (wr_any && (wr_idx == IW'(i))),
			.left_d  (left_d),
			.right_d (right_d),
			.q       (cell_q[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bul_pkg::ST_IDLE: begin
				if (req_valid) begin
					priority if (kind == bul_pkg::KIND_APPEND ||
						kind == bul_pkg::KIND_FRONT) begin
						state_d = bul_pkg::ST_APPLY;
					end else if (empty) begin
						state_d = bul_pkg::ST_DONE;
					end else if (kind == bul_pkg::KIND_REMOVE_FIRST ||
						kind == bul_pkg::KIND_REMOVE_ALL) begin
						state_d = bul_pkg::ST_SCAN_DROP;
					end else if (kind == bul_pkg::KIND_REMOVE_MIN) begin
						state_d = bul_pkg::ST_SCAN_MIN;
					end else begin
						state_d = bul_pkg::ST_DONE;
					end
				end
			end
			bul_pkg::ST_APPLY: state_d = bul_pkg::ST_DONE;
			bul_pkg::ST_SCAN_MIN: begin
				if (last_step) state_d = bul_pkg::ST_SCAN_DROP;
			end
			bul_pkg::ST_SCAN_DROP: begin
				if (last_step) state_d = bul_pkg::ST_DONE;
			end
			bul_pkg::ST_DONE: begin
				if (rsp_free) state_d = bul_pkg::ST_IDLE;
			end
			default: state_d = bul_pkg::ST_IDLE;
		endcase
	end

	// cell row control
	always_comb begin
		ctl     = '0;
		wr_any  = 1'b0;
		wr_idx  = '0;
		unique case (state_q)
			bul_pkg::ST_APPLY: begin
				ctl.wr_data = key_q;
				if (room) begin
					wr_any = 1'b1;
					if (kind_q == bul_pkg::KIND_APPEND) begin
						wr_idx = fill_q[IW-1:0];
					end else begin
						ctl.shr = 1'b1;
						wr_idx  = '0;
					end
				end
			end
			bul_pkg::ST_SCAN_MIN: begin
				ctl.shl     = 1'b1;
				ctl.wr_data = head;
				wr_any      = 1'b1;
				wr_idx      = IW'(fill_q - CW'(1));
			end
			bul_pkg::ST_SCAN_DROP: begin
				ctl.shl     = 1'b1;
				ctl.wr_data = head;
				wr_any      = !drop_now;
				wr_idx      = IW'(fill_q - CW'(1));
			end
			bul_pkg::ST_IDLE, bul_pkg::ST_DONE: begin
				ctl = '0;
			end
			default: ctl = '0;
		endcase
	end

	assign req_ready = state_q == bul_pkg::ST_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bul_pkg::ST_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				bul_pkg::ST_APPLY: begin
					if (room) fill_q <= fill_q + CW'(1);
				end
				bul_pkg::ST_SCAN_DROP: begin
					if (drop_now) fill_q <= fill_q - CW'(1);
				end
				bul_pkg::ST_IDLE, bul_pkg::ST_SCAN_MIN, bul_pkg::ST_DONE: begin
					fill_q <= fill_q;
				end
				default: fill_q <= fill_q;
			endcase
		end
	end

	// working and response payload, no reset needed
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			ok_q      <= res_ok_q;
			count_q   <= fill_q;
			removed_q <= res_rm_q;
		end
		unique case (state_q)
			bul_pkg::ST_IDLE: begin
				if (req_valid) begin
					kind_q    <= kind;
					key_q     <= value;
					steps_q   <= fill_q;
					min_q     <= head;
					dropped_q <= 1'b0;
					res_ok_q  <= 1'b0;
					res_rm_q  <= '0;
				end
			end
			bul_pkg::ST_APPLY: begin
				res_ok_q <= room;
			end
			bul_pkg::ST_SCAN_MIN: begin
				min_q <= min_next;
				if (last_step) begin
					// second pass drops the first entry equal to the minimum
					steps_q  <= fill_q;
					key_q    <= min_next;
					res_rm_q <= min_next;
				end else begin
					steps_q <= steps_q - CW'(1);
				end
			end
			bul_pkg::ST_SCAN_DROP: begin
				steps_q <= steps_q - CW'(1);
				if (drop_now) dropped_q <= 1'b1;
				if (last_step) begin
					res_ok_q <= (kind_q == bul_pkg::KIND_REMOVE_ALL) ||
						dropped_q || drop_now;
				end
			end
			bul_pkg::ST_DONE: begin
				steps_q <= steps_q;
			end
			default: steps_q <= steps_q;
		endcase
	end

	assign rsp_valid     = rsp_valid_q;
	assign ok            = ok_q;
	assign count         = count_q;
	assign removed_value = removed_q;

endmodule

// ----- rtl/core/bul_checker.sv -----
`timescale 1ns / 1ps

module bul_checker #(
	parameter int DEPTH = 16
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic                             ok,
	input logic [$clog2(DEPTH+1)-1:0]       count,
	input logic signed [bul_pkg::WordW-1:0] removed_value
);

	localparam int CW = $clog2(DEPTH + 1);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(count) && $stable(ok))
		else $error("response dropped or changed while stalled");

	// a taken request leaves the block busy in the cycle after the transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request port ready right after a transfer");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> count <= CW'(DEPTH))
		else $error("count beyond capacity");

	// a nonzero removed value only comes from a successful remove minimum
	a_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && removed_value != '0 |-> ok)
		else $error("removed value on a failed request");

	// a request taken while no response is pending never finishes on the cycle after the transfer
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !rsp_valid |=> !rsp_valid)
		else $error("response appeared too early");

endmodule

bind bounded_unsorted_list bul_checker #(.DEPTH(DEPTH)) u_bul_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req_valid),
	.req_ready     (req_ready),
	.rsp_valid     (rsp_valid),
	.rsp_ready     (rsp_ready),
	.ok            (ok),
	.count         (count),
	.removed_value (removed_value)
);
